// File: design/anbs_pkg.sv
// ----------------------------------------------------------------------------
// anbs_pkg - shared types and constants of the Annex-B NAL splitter
// Field widths, state encodings and the structs passed between its modules.
// ----------------------------------------------------------------------------
`default_nettype none

package anbs_pkg;

   localparam int BYTE_W      = 8;
   localparam int STAMP_W     = 32;
   localparam int TYPE_W      = 5;
   localparam int RATE_W      = 8;
   localparam int EMIT_W      = 3;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 6;

   localparam int TIMESTAMP_CLOCK_HZ_DEFAULT = 90000;
   localparam logic [RATE_W-1:0] FRAME_RATE_DEFAULT = 8'd30;

   typedef enum logic [1:0] {
      PH_EXPECT,
      PH_PAYLOAD,
      PH_DROP
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_MUL
   } ctl_state_type;

   typedef enum logic [1:0] {
      AR_IDLE,
      AR_DIV,
      AR_MUL
   } arith_phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  data_byte;
      logic               packet_end;
      logic [STAMP_W-1:0] frame_count;
      logic               count_valid;
   } item_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  payload_byte;
      logic               unit_first;
      logic               unit_last;
      logic [TYPE_W-1:0]  unit_type;
      logic [STAMP_W-1:0] rtp_time;
   } result_type;

   typedef struct packed {
      logic [EMIT_W-1:0] count;
      logic              open_unit;
   } plan_type;

   typedef struct packed {
      logic               start_mul;
      logic [STAMP_W-1:0] operand;
   } arith_req_type;

   typedef struct packed {
      logic busy;
      logic mul_done;
   } arith_sts_type;

endpackage

`default_nettype wire

// File: design/anbs_parser.sv
// ----------------------------------------------------------------------------
// anbs_parser - start code parser and held-byte state
// Decides the results of the held item, selects each result by index and
// updates the parse state on commit.
// ----------------------------------------------------------------------------
`default_nettype none

module anbs_parser (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  anbs_pkg::item_type            item,
   input  wire  [anbs_pkg::EMIT_W-1:0]         emit_idx,
   input  wire                                 commit,
   input  wire                                 time_we,
   input  wire  [anbs_pkg::STAMP_W-1:0]        time_value,
   output anbs_pkg::plan_type                  plan,
   output anbs_pkg::result_type                result
);

   anbs_pkg::phase_type              phase_ff, phase_in;
   logic [1:0]                       zrun_ff, zrun_in;
   logic                             fill_ff, fill_in;
   logic [anbs_pkg::BYTE_W-1:0]      held_ff, held_in;
   logic                             pfirst_ff, pfirst_in;
   logic [anbs_pkg::TYPE_W-1:0]      ctype_ff, ctype_in;
   logic [anbs_pkg::STAMP_W-1:0]     ctime_ff, ctime_in;

   logic                             held_en;
   logic                             held_last;
   logic [1:0]                       zeros;
   logic                             tail_en;
   logic                             open_unit;
   logic                             is_zero;
   logic                             is_sc;
   logic [anbs_pkg::EMIT_W-1:0]      count;
   logic [anbs_pkg::BYTE_W-1:0]      first_byte;
   logic [anbs_pkg::TYPE_W-1:0]      type_out;

   always_comb begin
      phase_in  = phase_ff;
      zrun_in   = zrun_ff;
      fill_in   = fill_ff;
      held_in   = held_ff;
      held_en   = 1'b0;
      held_last = 1'b0;
      zeros     = 2'd0;
      tail_en   = 1'b0;
      open_unit = 1'b0;
      is_zero   = (item.data_byte == 8'h00);
      is_sc     = (item.data_byte == 8'h01) && (zrun_ff >= 2'd2);

      case (phase_ff)
         anbs_pkg::PH_EXPECT: begin
            if (is_zero) begin
               if (zrun_ff != 2'd3) begin
                  zrun_in = zrun_ff + 2'd1;
               end else begin
                  phase_in = anbs_pkg::PH_DROP;
               end
            end else if (is_sc) begin
               open_unit = !item.packet_end;
            end else begin
               phase_in = anbs_pkg::PH_DROP;
            end
         end
         anbs_pkg::PH_PAYLOAD: begin
            if (is_sc) begin
               held_en   = fill_ff;
               held_last = 1'b1;
               fill_in   = 1'b0;
               zrun_in   = 2'd0;
               open_unit = !item.packet_end;
            end else if (is_zero) begin
               if (item.packet_end) begin
                  held_en   = fill_ff;
                  held_last = 1'b1;
               end else if (zrun_ff != 2'd3) begin
                  zrun_in = zrun_ff + 2'd1;
               end else begin
                  held_en = fill_ff;
                  held_in = 8'h00;
                  fill_in = 1'b1;
               end
            end else begin
               held_en = fill_ff;
               zeros   = (fill_ff && item.packet_end && zrun_ff == 2'd3) ? 2'd2 : zrun_ff;
               tail_en = item.packet_end;
               if (!item.packet_end) begin
                  held_in = item.data_byte;
                  fill_in = 1'b1;
                  zrun_in = 2'd0;
               end
            end
         end
         default: begin
         end
      endcase

      if (open_unit) begin
         phase_in = anbs_pkg::PH_PAYLOAD;
         fill_in  = 1'b0;
         held_in  = 8'h00;
         zrun_in  = 2'd0;
      end
      if (item.packet_end) begin
         phase_in = anbs_pkg::PH_EXPECT;
         zrun_in  = 2'd0;
         fill_in  = 1'b0;
         held_in  = 8'h00;
      end

      count = {2'b00, held_en} + {1'b0, zeros} + {2'b00, tail_en};
      plan.count     = count;
      plan.open_unit = open_unit;

      first_byte = held_en ? held_ff : ((zeros != 2'd0) ? 8'h00 : item.data_byte);
      type_out   = pfirst_ff ? first_byte[anbs_pkg::TYPE_W-1:0] : ctype_ff;

      // held byte leads, then the released zeros, then the final byte
      if (held_en && emit_idx == '0) begin
         result.payload_byte = held_ff;
         result.unit_last    = held_last;
      end else if (tail_en && emit_idx == count - 3'd1) begin
         result.payload_byte = item.data_byte;
         result.unit_last    = 1'b1;
      end else begin
         result.payload_byte = 8'h00;
         result.unit_last    = 1'b0;
      end
      result.unit_first = pfirst_ff && (emit_idx == '0);
      result.unit_type  = type_out;
      result.rtp_time   = ctime_ff;

      pfirst_in = pfirst_ff;
      ctype_in  = ctype_ff;
      if (count != '0) begin
         pfirst_in = 1'b0;
         ctype_in  = type_out;
      end
      if (open_unit) begin
         pfirst_in = 1'b1;
      end
      if (item.packet_end) begin
         pfirst_in = 1'b0;
      end
      ctime_in = time_we ? time_value : ctime_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= anbs_pkg::PH_EXPECT;
         zrun_ff   <= 2'd0;
         fill_ff   <= 1'b0;
         pfirst_ff <= 1'b0;
         ctype_ff  <= '0;
         ctime_ff  <= '0;
      end else begin
         if (commit) begin
            phase_ff  <= phase_in;
            zrun_ff   <= zrun_in;
            fill_ff   <= fill_in;
            pfirst_ff <= pfirst_in;
            ctype_ff  <= ctype_in;
         end
         ctime_ff <= ctime_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         held_ff <= held_in;
      end
   end

endmodule

`default_nettype wire

// File: design/anbs_arith.sv
// ----------------------------------------------------------------------------
// anbs_arith - shared adder for tick division and timestamp multiply
// One adder, stepped by a counter: restoring division of the clock rate by
// the frame rate on a register write, shift-add multiply per new unit.
// ----------------------------------------------------------------------------
`default_nettype none

module anbs_arith #(
   parameter int TIMESTAMP_CLOCK_HZ = anbs_pkg::TIMESTAMP_CLOCK_HZ_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_wen,
   input  wire  [anbs_pkg::RATE_W-1:0]      csr_wdata,
   input  wire  anbs_pkg::arith_req_type    req,
   output anbs_pkg::arith_sts_type          sts,
   output logic [anbs_pkg::STAMP_W-1:0]     product
);

   localparam int TICK_W = $clog2(TIMESTAMP_CLOCK_HZ + 1);
   localparam int ITER_W = $clog2(TICK_W);
   localparam int ACC_W  = anbs_pkg::STAMP_W;
   localparam logic [TICK_W-1:0] HZ_BITS     = TICK_W'(TIMESTAMP_CLOCK_HZ);
   localparam logic [TICK_W-1:0] TICKS_RESET =
      TICK_W'(TIMESTAMP_CLOCK_HZ / anbs_pkg::FRAME_RATE_DEFAULT);
   localparam logic [ITER_W-1:0] ITER_LAST   = ITER_W'(TICK_W - 1);

   anbs_pkg::arith_phase_type       aph_ff, aph_in;
   logic [ITER_W-1:0]               iter_ff, iter_in;
   logic [ACC_W-1:0]                acc_ff, acc_in;
   logic [ACC_W-1:0]                mcand_ff, mcand_in;
   logic [anbs_pkg::RATE_W-1:0]     rem_ff, rem_in;
   logic [anbs_pkg::RATE_W-1:0]     rate_ff, rate_in;
   logic [TICK_W-1:0]               ticks_ff, ticks_in;
   logic                            div_pend_ff, div_pend_in;
   logic                            mul_pend_ff, mul_pend_in;
   logic                            done_ff, done_in;

   logic [ACC_W-1:0]                add_a;
   logic [ACC_W-1:0]                add_b;
   logic                            add_cin;
   logic [ACC_W:0]                  sum;
   logic [ITER_W-1:0]               div_idx;
   logic [anbs_pkg::RATE_W:0]       r_trial;
   logic                            qbit;

   always_comb begin
      aph_in      = aph_ff;
      iter_in     = iter_ff;
      acc_in      = acc_ff;
      mcand_in    = mcand_ff;
      rem_in      = rem_ff;
      rate_in     = rate_ff;
      ticks_in    = ticks_ff;
      div_pend_in = div_pend_ff;
      mul_pend_in = mul_pend_ff || req.start_mul;
      done_in     = 1'b0;

      div_idx = ITER_LAST - iter_ff;
      r_trial = {rem_ff, HZ_BITS[div_idx]};

      add_a   = acc_ff;
      add_b   = (ticks_ff[iter_ff]) ? mcand_ff : '0;
      add_cin = 1'b0;
      if (aph_ff == anbs_pkg::AR_DIV) begin
         add_a   = ACC_W'(r_trial);
         add_b   = ~ACC_W'(rate_ff);
         add_cin = 1'b1;
      end
      sum  = {1'b0, add_a} + {1'b0, add_b} + (ACC_W + 1)'(add_cin);
      qbit = sum[ACC_W];

      case (aph_ff)
         anbs_pkg::AR_IDLE: begin
            iter_in = '0;
            acc_in  = '0;
            if (req.start_mul || mul_pend_ff) begin
               aph_in      = anbs_pkg::AR_MUL;
               mcand_in    = req.operand;
               mul_pend_in = 1'b0;
            end else if (div_pend_ff) begin
               aph_in      = anbs_pkg::AR_DIV;
               rem_in      = '0;
               div_pend_in = 1'b0;
            end
         end
         anbs_pkg::AR_DIV: begin
            rem_in  = qbit ? sum[anbs_pkg::RATE_W-1:0] : r_trial[anbs_pkg::RATE_W-1:0];
            acc_in  = {acc_ff[ACC_W-2:0], qbit};
            iter_in = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_LAST) begin
               ticks_in = acc_in[TICK_W-1:0];
               aph_in   = anbs_pkg::AR_IDLE;
            end
         end
         anbs_pkg::AR_MUL: begin
            acc_in   = sum[ACC_W-1:0];
            mcand_in = {mcand_ff[ACC_W-2:0], 1'b0};
            iter_in  = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_LAST) begin
               aph_in  = anbs_pkg::AR_IDLE;
               done_in = 1'b1;
            end
         end
         default: begin
            aph_in = anbs_pkg::AR_IDLE;
         end
      endcase

      if (csr_wen) begin
         rate_in     = (csr_wdata == '0) ? anbs_pkg::FRAME_RATE_DEFAULT : csr_wdata;
         div_pend_in = 1'b1;
      end

      sts.busy     = (aph_ff != anbs_pkg::AR_IDLE) || div_pend_ff || mul_pend_ff;
      sts.mul_done = done_ff;
      product      = acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         aph_ff      <= anbs_pkg::AR_IDLE;
         iter_ff     <= '0;
         rate_ff     <= anbs_pkg::FRAME_RATE_DEFAULT;
         ticks_ff    <= TICKS_RESET;
         div_pend_ff <= 1'b0;
         mul_pend_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         aph_ff      <= aph_in;
         iter_ff     <= iter_in;
         rate_ff     <= rate_in;
         ticks_ff    <= ticks_in;
         div_pend_ff <= div_pend_in;
         mul_pend_ff <= mul_pend_in;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      rem_ff   <= rem_in;
   end

endmodule

`default_nettype wire

// File: design/annexb_nal_splitter_unit.sv
// ----------------------------------------------------------------------------
// annexb_nal_splitter_unit - H.264 Annex-B byte stream to NAL unit items
// Strips start codes, marks unit bounds and stamps each unit with a
// time (90 kHz by default) derived from the packet's frame count.
// ----------------------------------------------------------------------------
//  channel  dir  handshake             content
//  req_     in   tvalid/tready         one packet byte, packet end, frame count
//  rsp_     out  tvalid/tready         one payload byte, first/last, type, time
//  csr_     in   wen                   frame rate
//
//  An item causes n results, n = 0..4; a result waits while rsp_tready is
//  low. An item that opens a unit also runs the shift-add multiply on the
//  shared adder. A frame rate write holds req_tready low while the same
//  adder divides the clock rate by it.
//  Reset is synchronous; afterwards the block expects a start code.
// ----------------------------------------------------------------------------
`default_nettype none

module annexb_nal_splitter_unit #(
   parameter int TIMESTAMP_CLOCK_HZ = anbs_pkg::TIMESTAMP_CLOCK_HZ_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [anbs_pkg::REQ_TDATA_W-1:0]     req_tdata,   // data_byte, frame_count
   input  wire                                  req_tlast,   // packet_end
   input  wire                                  req_tuser,   // count_valid
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [anbs_pkg::RSP_TDATA_W-1:0]     rsp_tdata,   // payload_byte, rtp_time
   output logic                                 rsp_tlast,   // unit_last
   output logic [anbs_pkg::RSP_TUSER_W-1:0]     rsp_tuser,   // unit_first, unit_type
   input  wire                                  csr_wen,
   input  wire  [anbs_pkg::RATE_W-1:0]          csr_wdata
);

   anbs_pkg::ctl_state_type           state_ff, state_in;
   logic [anbs_pkg::EMIT_W-1:0]       emit_idx_ff, emit_idx_in;
   anbs_pkg::item_type                item_ff, item_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   anbs_pkg::result_type              rsp_item_ff, rsp_item_in;

   anbs_pkg::plan_type                plan;
   anbs_pkg::result_type              result;
   anbs_pkg::arith_req_type           arith_req;
   anbs_pkg::arith_sts_type           arith_sts;
   logic [anbs_pkg::STAMP_W-1:0]      product;
   logic                              accept;
   logic                              commit;
   logic                              time_we;

   anbs_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .item       (item_ff),
      .emit_idx   (emit_idx_ff),
      .commit     (commit),
      .time_we    (time_we),
      .time_value (product),
      .plan       (plan),
      .result     (result)
   );

   anbs_arith #(
      .TIMESTAMP_CLOCK_HZ (TIMESTAMP_CLOCK_HZ)
   ) u_arith (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .req       (arith_req),
      .sts       (arith_sts),
      .product   (product)
   );

   always_comb begin
      state_in     = state_ff;
      emit_idx_in  = emit_idx_ff;
      item_in      = item_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      commit       = 1'b0;
      time_we      = 1'b0;
      req_tready   = 1'b0;
      accept       = 1'b0;

      arith_req.start_mul = 1'b0;
      arith_req.operand   = item_ff.count_valid ? item_ff.frame_count : '0;

      case (state_ff)
         anbs_pkg::ST_IDLE: begin
            req_tready = !arith_sts.busy;
            accept     = req_tvalid && req_tready;
            if (accept) begin
               item_in.data_byte   = req_tdata[anbs_pkg::BYTE_W-1:0];
               item_in.frame_count = req_tdata[anbs_pkg::REQ_TDATA_W-1:anbs_pkg::BYTE_W];
               item_in.packet_end  = req_tlast;
               item_in.count_valid = req_tuser;
               emit_idx_in         = '0;
               state_in            = anbs_pkg::ST_EMIT;
            end
         end
         anbs_pkg::ST_EMIT: begin
            if (emit_idx_ff == plan.count) begin
               if (plan.open_unit) begin
                  arith_req.start_mul = 1'b1;
                  state_in            = anbs_pkg::ST_MUL;
               end else begin
                  commit   = 1'b1;
                  state_in = anbs_pkg::ST_IDLE;
               end
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_item_in  = result;
               rsp_valid_in = 1'b1;
               emit_idx_in  = emit_idx_ff + anbs_pkg::EMIT_W'(1);
            end
         end
         anbs_pkg::ST_MUL: begin
            if (arith_sts.mul_done) begin
               commit   = 1'b1;
               time_we  = 1'b1;
               state_in = anbs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = anbs_pkg::ST_IDLE;
         end
      endcase

      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = {rsp_item_ff.rtp_time, rsp_item_ff.payload_byte};
      rsp_tlast  = rsp_item_ff.unit_last;
      rsp_tuser  = {rsp_item_ff.unit_type, rsp_item_ff.unit_first};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= anbs_pkg::ST_IDLE;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_item_ff <= rsp_item_in;
   end

   a_mul_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == anbs_pkg::ST_MUL) |-> (arith_sts.busy || arith_sts.mul_done))
      else $error("multiply wait with shared adder idle");

   a_accept_emit: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == anbs_pkg::ST_EMIT && emit_idx_ff == '0))
      else $error("accepted item not followed by emission from index zero");

   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == anbs_pkg::ST_EMIT) |-> (emit_idx_ff <= plan.count))
      else $error("emission index beyond result count");

endmodule

`default_nettype wire
